// ===== rtl/rfct_pkg.sv =====
// ---------------------------------------------------------------------------
// rfct_pkg
// Shared types and constants of the ranked frequency count table.
// ---------------------------------------------------------------------------
package rfct_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int USED_W      = SLOT_W + 1;
  localparam int KEY_W       = 32;
  localparam int CNT_W       = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // one slot of the table: key, count and its current rank
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  cnt;
    logic [SLOT_W-1:0] rnk;
  } slot_t;

  localparam int SLOT_ENTRY_W = $bits(slot_t);

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  vector;
    logic [CNT_W-1:0]  count;
    logic [SLOT_W-1:0] rank;
    logic              is_new;
    logic              dropped;
  } res_t;

  typedef struct packed {
    res_t              res;
    logic [USED_W-1:0] distinct;
    logic [CNT_W-1:0]  overflow;
  } fin_t;

endpackage

// ===== rtl/rfct_ram.sv =====
// ---------------------------------------------------------------------------
// rfct_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module rfct_ram #(
  parameter int DW = 8,
  parameter int AW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rfct_engine.sv =====
// ---------------------------------------------------------------------------
// rfct_engine
// Sequencer around the slot memory and the rank memory: lookup scan,
// rank bubbling, insertion and rank reads.
// ---------------------------------------------------------------------------
module rfct_engine import rfct_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              req_type_i,
  input  logic [KEY_W-1:0]  fail_vector_i,
  input  logic [SLOT_W-1:0] rank_index_i,
  input  logic              cfg_we_i,
  input  logic [USED_W-1:0] cfg_data_i,
  output logic              busy_o,
  output logic              fin_valid_o,
  input  logic              fin_ready_i,
  output fin_t              fin_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RDSAR  = 4'd1;
  localparam logic [3:0] S_RDSLOT = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_BSAR   = 4'd4;
  localparam logic [3:0] S_BCNT   = 4'd5;
  localparam logic [3:0] S_FINAL  = 4'd6;
  localparam logic [3:0] S_MISS   = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0] rank_q, rank_d;
  logic [SLOT_W-1:0] above_q, above_d;
  logic [SLOT_W-1:0] rdrank_q, rdrank_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [USED_W-1:0] used_q, used_d;
  logic [USED_W-1:0] max_q, max_d;
  logic [CNT_W-1:0]  rej_q, rej_d;
  res_t              res_q, res_d;

  logic              sm_we;
  logic [SLOT_W-1:0] sm_waddr, sm_raddr;
  slot_t             sm_wdata, sm_rdata;
  logic              ra_we;
  logic [SLOT_W-1:0] ra_waddr, ra_raddr, ra_wdata, ra_rdata;
  logic [USED_W-1:0] limit;

  rfct_ram #(.DW(SLOT_ENTRY_W), .AW(SLOT_W)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (sm_we),
    .waddr_i (sm_waddr),
    .wdata_i (sm_wdata),
    .raddr_i (sm_raddr),
    .rdata_o (sm_rdata)
  );

  // slot at each rank
  rfct_ram #(.DW(SLOT_W), .AW(SLOT_W)) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (ra_we),
    .waddr_i (ra_waddr),
    .wdata_i (ra_wdata),
    .raddr_i (ra_raddr),
    .rdata_o (ra_rdata)
  );

  assign limit = (max_q == '0 || max_q > USED_W'(TABLE_DEPTH)) ?
                 USED_W'(TABLE_DEPTH) : max_q;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    slot_d   = slot_q;
    rank_d   = rank_q;
    above_d  = above_q;
    rdrank_d = rdrank_q;
    cnt_d    = cnt_q;
    key_d    = key_q;
    used_d   = used_q;
    max_d    = max_q;
    rej_d    = rej_q;
    res_d    = res_q;
    sm_we    = 1'b0;
    sm_waddr = '0;
    sm_wdata = '0;
    sm_raddr = '0;
    ra_we    = 1'b0;
    ra_waddr = '0;
    ra_wdata = '0;
    ra_raddr = '0;
    fin_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cfg_we_i) begin
          max_d  = cfg_data_i;
          used_d = '0;
          rej_d  = '0;
        end else if (start_i) begin
          key_d    = fail_vector_i;
          rdrank_d = rank_index_i;
          if (req_type_i) begin
            if ({1'b0, rank_index_i} < used_q) begin
              ra_raddr = rank_index_i;
              state_d  = S_RDSAR;
            end else begin
              res_d   = '0;
              state_d = S_FIN;
            end
          end else if (used_q == '0) begin
            state_d = S_MISS;
          end else begin
            sm_raddr = '0;
            idx_d    = '0;
            state_d  = S_SCAN;
          end
        end
      end
      S_RDSAR: begin
        sm_raddr = ra_rdata;
        state_d  = S_RDSLOT;
      end
      S_RDSLOT: begin
        res_d   = '{valid: 1'b1, vector: sm_rdata.key, count: sm_rdata.cnt,
                    rank: rdrank_q, is_new: 1'b0, dropped: 1'b0};
        state_d = S_FIN;
      end
      S_SCAN: begin
        // word for idx_q is on the read port; fetch the next one meanwhile
        sm_raddr = idx_q + 1'b1;
        if (sm_rdata.key == key_q) begin
          cnt_d  = (sm_rdata.cnt == CNT_MAX) ? sm_rdata.cnt : sm_rdata.cnt + 1'b1;
          slot_d = idx_q;
          rank_d = sm_rdata.rnk;
          if (sm_rdata.rnk == '0) begin
            state_d = S_FINAL;
          end else begin
            ra_raddr = sm_rdata.rnk - 1'b1;
            state_d  = S_BSAR;
          end
        end else if (USED_W'(idx_q) + 1'b1 < used_q) begin
          idx_d = idx_q + 1'b1;
        end else begin
          state_d = S_MISS;
        end
      end
      S_BSAR: begin
        above_d  = ra_rdata;
        sm_raddr = ra_rdata;
        state_d  = S_BCNT;
      end
      S_BCNT: begin
        if (cnt_q > sm_rdata.cnt) begin
          // entry above drops one rank; moving slot is written at the end
          sm_we    = 1'b1;
          sm_waddr = above_q;
          sm_wdata = '{key: sm_rdata.key, cnt: sm_rdata.cnt, rnk: rank_q};
          ra_we    = 1'b1;
          ra_waddr = rank_q;
          ra_wdata = above_q;
          rank_d   = rank_q - 1'b1;
          if (rank_q == SLOT_W'(1)) begin
            state_d = S_FINAL;
          end else begin
            ra_raddr = rank_q - SLOT_W'(2);
            state_d  = S_BSAR;
          end
        end else begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        sm_we    = 1'b1;
        sm_waddr = slot_q;
        sm_wdata = '{key: key_q, cnt: cnt_q, rnk: rank_q};
        ra_we    = 1'b1;
        ra_waddr = rank_q;
        ra_wdata = slot_q;
        res_d    = '{valid: 1'b1, vector: key_q, count: cnt_q, rank: rank_q,
                     is_new: 1'b0, dropped: 1'b0};
        state_d  = S_FIN;
      end
      S_MISS: begin
        if (used_q < limit) begin
          sm_we    = 1'b1;
          sm_waddr = used_q[SLOT_W-1:0];
          sm_wdata = '{key: key_q, cnt: CNT_W'(1), rnk: used_q[SLOT_W-1:0]};
          ra_we    = 1'b1;
          ra_waddr = used_q[SLOT_W-1:0];
          ra_wdata = used_q[SLOT_W-1:0];
          used_d   = used_q + 1'b1;
          res_d    = '{valid: 1'b1, vector: key_q, count: CNT_W'(1),
                       rank: used_q[SLOT_W-1:0], is_new: 1'b1, dropped: 1'b0};
        end else begin
          if (rej_q != CNT_MAX) begin
            rej_d = rej_q + 1'b1;
          end
          res_d = '{valid: 1'b0, vector: key_q, count: '0, rank: '0,
                    is_new: 1'b0, dropped: 1'b1};
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        fin_valid_o = 1'b1;
        if (fin_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      max_q   <= '0;
      rej_q   <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      max_q   <= max_d;
      rej_q   <= rej_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    slot_q   <= slot_d;
    rank_q   <= rank_d;
    above_q  <= above_d;
    rdrank_q <= rdrank_d;
    cnt_q    <= cnt_d;
    key_q    <= key_d;
    res_q    <= res_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign fin_o  = '{res: res_q, distinct: used_q, overflow: rej_q};

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= USED_W'(TABLE_DEPTH))
    else $error("entry count beyond capacity");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> USED_W'(idx_q) < used_q)
    else $error("scan past the filled slots");

  a_bubble_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BSAR || state_q == S_BCNT) |-> rank_q != '0)
    else $error("bubbling from the top rank");

  a_miss_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MISS && used_q < limit) |=> used_q == $past(used_q) + 1'b1)
    else $error("insertion did not grow the table");

endmodule

// ===== rtl/ranked_frequency_count_table_unit.sv =====
// ---------------------------------------------------------------------------
// ranked_frequency_count_table_unit
// Top-k frequency counter with ranked read-out.
// ---------------------------------------------------------------------------
// One word at a time. A read of a filled rank looks up its slot in the rank
// memory, then reads that slot; a read past the filled ranks returns an
// invalid entry. A record scans up to distinct_count entries of the slot
// memory, one entry per cycle, then bubbles up one rank at a time; the
// single read port of the slot memory sets this pace. The result sits in an
// output register, so the next word is taken while it waits. A write to
// the limit (cfg_data_i) is accepted only while idle and clears the table
// and the overflow counter at once.
module ranked_frequency_count_table_unit import rfct_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              req_type_i,
  input  logic [KEY_W-1:0]  fail_vector_i,
  input  logic [SLOT_W-1:0] rank_index_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [USED_W-1:0] cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              entry_valid_o,
  output logic [KEY_W-1:0]  entry_vector_o,
  output logic [CNT_W-1:0]  entry_count_o,
  output logic [SLOT_W-1:0] entry_rank_o,
  output logic              was_new_o,
  output logic              was_dropped_o,
  output logic [USED_W-1:0] distinct_count_o,
  output logic [CNT_W-1:0]  overflow_count_o
);

  logic busy, fin_valid, fin_ready, out_valid_q;
  fin_t fin, out_q;

  rfct_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_valid_i && !in_stall_o),
    .req_type_i    (req_type_i),
    .fail_vector_i (fail_vector_i),
    .rank_index_i  (rank_index_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .busy_o        (busy),
    .fin_valid_o   (fin_valid),
    .fin_ready_i   (fin_ready),
    .fin_o         (fin)
  );

  assign in_stall_o  = busy || cfg_valid_i;
  assign cfg_ready_o = !busy;
  assign fin_ready   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_ready) begin
      out_valid_q <= fin_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_ready && fin_valid) begin
      out_q <= fin;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign entry_valid_o    = out_q.res.valid;
  assign entry_vector_o   = out_q.res.vector;
  assign entry_count_o    = out_q.res.count;
  assign entry_rank_o     = out_q.res.rank;
  assign was_new_o        = out_q.res.is_new;
  assign was_dropped_o    = out_q.res.dropped;
  assign distinct_count_o = out_q.distinct;
  assign overflow_count_o = out_q.overflow;

endmodule

// ===== dv/tb_ranked_frequency_count_table_unit.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_ranked_frequency_count_table_unit
// Self-checking bench for the ranked frequency count table. Directed tests
// cover empty reads, rank bubbling, limits and drops. Randomised phases
// then mix records and reads under several limits, with idle gaps and
// output stalls on both sides.
// ---------------------------------------------------------------------------
module tb_ranked_frequency_count_table_unit;
  import rfct_pkg::*;

  localparam int LIMIT_CYCLES = 10000000;
  localparam int ITEMS        = 1450;
  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  vector;
    logic [CNT_W-1:0]  count;
    logic [SLOT_W-1:0] rank;
    logic              is_new;
    logic              dropped;
    logic [USED_W-1:0] distinct;
    logic [CNT_W-1:0]  overflow;
  } entry_rpt_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              req_type_i = REQ_RECORD;
  logic [KEY_W-1:0]  fail_vector_i = '0;
  logic [SLOT_W-1:0] rank_index_i = '0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [USED_W-1:0] cfg_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              entry_valid_o;
  logic [KEY_W-1:0]  entry_vector_o;
  logic [CNT_W-1:0]  entry_count_o;
  logic [SLOT_W-1:0] entry_rank_o;
  logic              was_new_o;
  logic              was_dropped_o;
  logic [USED_W-1:0] distinct_count_o;
  logic [CNT_W-1:0]  overflow_count_o;

  ranked_frequency_count_table_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i, .fail_vector_i,
    .rank_index_i, .cfg_valid_i, .cfg_ready_o, .cfg_data_i, .out_valid_o,
    .out_stall_i, .entry_valid_o, .entry_vector_o, .entry_count_o,
    .entry_rank_o, .was_new_o, .was_dropped_o, .distinct_count_o,
    .overflow_count_o
  );

  always #2 clk_i = ~clk_i;

  // predictor copy of the table
  logic [KEY_W-1:0]  tbl_key  [TABLE_DEPTH];
  logic [CNT_W-1:0]  tbl_cnt  [TABLE_DEPTH];
  int unsigned       slot_of_rank [TABLE_DEPTH];
  int unsigned       rank_of  [TABLE_DEPTH];
  int unsigned       n_used;
  logic [CNT_W-1:0]  n_rejected;
  logic [USED_W-1:0] limit_reg;

  entry_rpt_t  pending_rpt[$];
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_drops = 0;
  int unsigned n_phases = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit          no_idle = 0;
  logic [KEY_W-1:0] pool [300];

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic entry_rpt_t predict_entry(logic rt, logic [KEY_W-1:0] key,
                                               logic [SLOT_W-1:0] ridx);
    entry_rpt_t  e;
    int unsigned i, s, r, lim, up;
    e = '0;
    if (rt == REQ_READ) begin
      if (ridx < n_used) begin
        s = slot_of_rank[ridx];
        e.valid = 1'b1; e.vector = tbl_key[s]; e.count = tbl_cnt[s]; e.rank = ridx;
      end
    end else begin
      for (i = 0; i < n_used; i++) if (tbl_key[i] == key) break;
      lim = (limit_reg == 0 || limit_reg > TABLE_DEPTH) ? TABLE_DEPTH : limit_reg;
      if (i < n_used) begin
        s = i;
        if (tbl_cnt[s] != CNT_MAX) tbl_cnt[s]++;
        r = rank_of[s];
        while (r > 0) begin
          up = slot_of_rank[r-1];
          if (!(tbl_cnt[s] > tbl_cnt[up])) break;
          slot_of_rank[r-1] = s; slot_of_rank[r] = up;
          rank_of[up] = r; rank_of[s] = r - 1;
          r--;
        end
        e.valid = 1'b1; e.vector = key; e.count = tbl_cnt[s]; e.rank = SLOT_W'(r);
      end else if (n_used < lim) begin
        s = n_used;
        tbl_key[s] = key; tbl_cnt[s] = CNT_W'(1); slot_of_rank[s] = s; rank_of[s] = s;
        n_used++;
        e.valid = 1'b1; e.vector = key; e.count = CNT_W'(1); e.rank = SLOT_W'(s);
        e.is_new = 1'b1;
      end else begin
        if (n_rejected != CNT_MAX) n_rejected++;
        e.vector = key; e.dropped = 1'b1;
      end
    end
    e.distinct = USED_W'(n_used);
    e.overflow = n_rejected;
    return e;
  endfunction

  task automatic send_word(logic rt, logic [KEY_W-1:0] key, logic [SLOT_W-1:0] ridx);
    int unsigned g;
    in_valid_i <= 1'b1; req_type_i <= rt; fail_vector_i <= key; rank_index_i <= ridx;
    do @(posedge clk_i); while (in_stall_o);
    pending_rpt.push_back(predict_entry(rt, key, ridx));
    if (rt == REQ_RECORD && pending_rpt[$].dropped) n_drops++;
    n_sent++;
    g = pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    while (pending_rpt.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // limit write; clears the table, so only issued once the block is idle
  task automatic set_limit(logic [USED_W-1:0] v);
    in_valid_i <= 1'b0;
    drain();
    cfg_valid_i <= 1'b1; cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limit_reg = v; n_used = 0; n_rejected = '0;
    n_phases++;
  endtask

  // mostly short output stalls, now and then a long one
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (!no_idle && $urandom_range(0, 99) < 2) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(8, 40);
    end else begin
      out_stall_i <= (no_idle || $urandom_range(0, 99) < 70) ? 1'b0 :
                     ($urandom_range(0, 9) == 0 ? ($urandom_range(0, 1) == 1) : 1'b1);
    end
  end

  always @(posedge clk_i) begin
    entry_rpt_t exp_e, got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{entry_valid_o, entry_vector_o, entry_count_o, entry_rank_o, was_new_o,
              was_dropped_o, distinct_count_o, overflow_count_o};
      if (pending_rpt.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
      end else begin
        exp_e = pending_rpt.pop_front();
        n_checked++;
        if (got != exp_e) begin
          $display("%0t: mismatch exp v=%0d vec=%h cnt=%0d rk=%0d new=%0d drop=%0d d=%0d ov=%0d",
                   $time, exp_e.valid, exp_e.vector, exp_e.count, exp_e.rank, exp_e.is_new,
                   exp_e.dropped, exp_e.distinct, exp_e.overflow);
          $display("%0t:          got v=%0d vec=%h cnt=%0d rk=%0d new=%0d drop=%0d d=%0d ov=%0d",
                   $time, got.valid, got.vector, got.count, got.rank, got.is_new,
                   got.dropped, got.distinct, got.overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("[ranked_frequency_count_table_unit] ERROR");
      $finish;
    end
  end

  task automatic test_empty_reads();
    send_word(REQ_READ, '0, '0);
    send_word(REQ_READ, '1, '1);
    send_word(REQ_RECORD, '0, '1);
  endtask

  task automatic test_bubble();
    set_limit(9'd0);
    send_word(REQ_RECORD, 32'hFFFF_FFFF, '0);
    send_word(REQ_RECORD, 32'h0000_0001, '0);
    send_word(REQ_RECORD, 32'hA5A5_5A5A, '0);
    send_word(REQ_RECORD, 32'hA5A5_5A5A, '0); // climbs to the top
    send_word(REQ_RECORD, 32'h0000_0001, '0); // passes the lower count, stops at the equal one
    send_word(REQ_RECORD, 32'h0000_0001, '0);
    send_word(REQ_READ, '0, 8'd0);
    send_word(REQ_READ, '0, 8'd2);
    send_word(REQ_READ, '0, 8'd3);
  endtask

  task automatic test_limit_drop();
    set_limit(9'd1);
    send_word(REQ_RECORD, 32'h1234_5678, '0);
    send_word(REQ_RECORD, 32'h8765_4321, '0); // table full, dropped
    send_word(REQ_RECORD, 32'h8765_4321, '0);
    send_word(REQ_RECORD, 32'h1234_5678, '0);
    send_word(REQ_READ, '0, 8'd1);
    set_limit(9'd511); // above capacity acts as full depth
    send_word(REQ_RECORD, 32'h5555_AAAA, '0);
    send_word(REQ_READ, '0, 8'd0);
  endtask

  task automatic test_random();
    logic [USED_W-1:0] lims [8] = '{9'd0, 9'd256, 9'd1, 9'd511, 9'd255, 9'd3, 9'd2, 9'd300};
    int unsigned p, k, psz, nitems, r;
    logic [KEY_W-1:0] key;
    for (k = 0; k < 300; k++) pool[k] = $urandom;
    pool[0] = '0; pool[1] = '1;
    p = 0;
    while (n_sent < ITEMS) begin
      set_limit(p < 8 ? lims[p] : 9'($urandom_range(0, 20)));
      no_idle = ($urandom_range(0, 3) == 0);
      psz = ($urandom_range(0, 4) == 0) ? 300 : $urandom_range(2, 20);
      nitems = (psz == 300) ? 320 : $urandom_range(40, 120);
      for (k = 0; k < nitems && n_sent < ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 20)
          send_word(REQ_READ, $urandom,
                    $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 24)));
        else begin
          key = (r < 28) ? 32'($urandom) : pool[$urandom_range(0, psz - 1)];
          send_word(REQ_RECORD, key, 8'($urandom));
        end
      end
      p++;
    end
    no_idle = 0;
  endtask

  initial begin
    limit_reg = '0; n_used = 0; n_rejected = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_reads();
    test_bubble();
    test_limit_drop();
    test_random();
    in_valid_i <= 1'b0;
    drain();
    repeat (100) @(posedge clk_i);
    $display("Covered %0d words over %0d limit settings, %0d results checked, %0d drops.",
             n_sent, n_phases, n_checked, n_drops);
    if (errors == 0 && pending_rpt.size() == 0) begin
      $display("[ranked_frequency_count_table_unit] OK");
    end else begin
      $display("[ranked_frequency_count_table_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rfct_pkg.sv
rtl/rfct_ram.sv
rtl/rfct_engine.sv
rtl/ranked_frequency_count_table_unit.sv
dv/tb_ranked_frequency_count_table_unit.sv
